@@ hw/rtl/mfq_pkg.sv @@
package mfq_pkg;

	localparam int NUM_LEVELS          = 3;
	localparam int DEFAULT_QUEUE_DEPTH = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1 = 1'b1;

	localparam logic [15:0] QUANTUM0_RST = 16'd8;
	localparam logic [15:0] QUANTUM1_RST = 16'd16;

	localparam logic OP_SUBMIT   = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [7:0] PRIO_HIGH = 8'd1;
	localparam logic [7:0] PRIO_LOW  = 8'd0;

	localparam logic [1:0] LEVEL_0 = 2'd0;
	localparam logic [1:0] LEVEL_1 = 2'd1;
	localparam logic [1:0] LEVEL_2 = 2'd2;

	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_BAD_PRIO = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_DEMOTED  = 3'd3;
	localparam logic [2:0] ST_FINISHED = 3'd4;
	localparam logic [2:0] ST_IDLE     = 3'd5;
	localparam logic [2:0] ST_DROPPED  = 3'd6;

	typedef struct packed {
		logic        op;
		logic [15:0] proc_id;
		logic [15:0] burst_time;
		logic [7:0]  priority_req;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_id;
		logic [15:0] time_remaining;
		logic [1:0]  served_level;
		logic [7:0]  out_priority;
	} out_item_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] burst;
		logic [7:0]  prio;
	} entry_t;

	// level -> control
	typedef struct packed {
		logic   nonempty;
		logic   full;
		entry_t head;
	} lvl_stat_t;

	// control -> level
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t wdata;
	} lvl_cmd_t;

endpackage

@@ hw/rtl/multilevel_feedback_queue_scheduler_top.sv @@
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | in_data  (in_item_t)
// out     | output    | out_valid / out_stall | out_data (out_item_t)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item passes
// through the input register and then the result register before it can be taken.
// Queue state updates as the item moves from the input register to the result register.
// Head entries are prefetched into a register per level with write bypass.
// Reset clears pointers and counts, loads default quanta; queue slots are not reset.
// A stalled result holds; one more item may wait in the input register behind it.
module multilevel_feedback_queue_scheduler_top
	import mfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                      item_valid_s1;
	in_item_t                  item_s1;
	logic                      out_valid_q;
	out_item_t                 out_data_q;
	logic [15:0]               quantum0_q;
	logic [15:0]               quantum1_q;
	logic                      advance;
	logic                      in_take;
	lvl_stat_t [NUM_LEVELS-1:0] lvl_stat;
	lvl_cmd_t  [NUM_LEVELS-1:0] lvl_cmd;
	out_item_t                 res;

	assign advance  = item_valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = item_valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum0_q <= QUANTUM0_RST;
			quantum1_q <= QUANTUM1_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUANTUM0: quantum0_q <= cfg_data;
				REG_QUANTUM1: quantum1_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			item_valid_s1 <= in_take || (item_valid_s1 && !advance);
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q <= res;
		end
	end

	for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
		mfq_level #(
			.DEPTH(QUEUE_DEPTH)
		) u_level (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (lvl_cmd[g]),
			.stat  (lvl_stat[g])
		);
	end

	mfq_decide u_decide (
		.go      (advance),
		.item    (item_s1),
		.quantum0(quantum0_q),
		.quantum1(quantum1_q),
		.stat    (lvl_stat),
		.cmd     (lvl_cmd),
		.res     (res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ hw/rtl/mfq_level.sv @@
module mfq_level
	import mfq_pkg::*;
#(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  lvl_cmd_t  cmd,
	output lvl_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem [DEPTH];
	entry_t           head_data_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] head_d;
	logic [PTR_W-1:0] tail_d;

	assign head_d = cmd.pop ? ((head_q == PTR_LAST) ? '0 : PTR_W'(head_q + 1'b1)) : head_q;
	assign tail_d = cmd.push ? ((tail_q == PTR_LAST) ? '0 : PTR_W'(tail_q + 1'b1)) : tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (cmd.push && !cmd.pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (cmd.pop && !cmd.push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= cmd.wdata;
		end
	end

	// show-ahead head register with bypass for a write into the slot being read
	always_ff @(posedge clk) begin
		if (cmd.push && (tail_q == head_d)) begin
			head_data_q <= cmd.wdata;
		end else begin
			head_data_q <= mem[head_d];
		end
	end

	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == CNT_FULL);
	assign stat.head     = head_data_q;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q != CNT_FULL))
		else $error("push into full level");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop from empty level");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == '0) || (count_q == CNT_FULL)) |-> (head_q == tail_q))
		else $error("ring pointers disagree with count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("level count out of range");

endmodule

@@ hw/rtl/mfq_decide.sv @@
module mfq_decide
	import mfq_pkg::*;
(
	input  logic                         go,
	input  in_item_t                     item,
	input  logic [15:0]                  quantum0,
	input  logic [15:0]                  quantum1,
	input  lvl_stat_t [NUM_LEVELS-1:0]   stat,
	output lvl_cmd_t  [NUM_LEVELS-1:0]   cmd,
	output out_item_t                    res
);

	logic        any_ready;
	logic [1:0]  srv_lv;
	logic [1:0]  sub_lv;
	logic [1:0]  dem_lv;
	entry_t      head;
	logic [15:0] quantum;
	logic [15:0] rem;

	always_comb begin
		priority if (stat[0].nonempty) begin
			srv_lv = LEVEL_0;
		end else if (stat[1].nonempty) begin
			srv_lv = LEVEL_1;
		end else begin
			srv_lv = LEVEL_2;
		end
	end

	assign any_ready = stat[0].nonempty || stat[1].nonempty || stat[2].nonempty;
	assign sub_lv    = (item.priority_req == PRIO_HIGH) ? LEVEL_0 : LEVEL_1;
	assign dem_lv    = 2'(srv_lv + 2'd1);
	assign head      = stat[srv_lv].head;
	assign quantum   = (srv_lv == LEVEL_0) ? quantum0 : quantum1;
	assign rem       = 16'(head.burst - quantum);

	always_comb begin
		cmd = '0;
		res = '0;
		if (item.op == OP_SUBMIT) begin
			if (item.priority_req == PRIO_HIGH || item.priority_req == PRIO_LOW) begin
				if (stat[sub_lv].full) begin
					res.status = ST_FULL;
				end else begin
					res.status          = ST_ACCEPTED;
					cmd[sub_lv].push    = go;
					cmd[sub_lv].wdata   = '{id: item.proc_id, burst: item.burst_time,
						prio: item.priority_req};
				end
			end else begin
				res.status = ST_BAD_PRIO;
			end
		end else if (!any_ready) begin
			res.status = ST_IDLE;
		end else begin
			cmd[srv_lv].pop  = go;
			res.out_id       = head.id;
			res.served_level = srv_lv;
			res.out_priority = head.prio;
			if (srv_lv != LEVEL_2 && head.burst > quantum) begin
				res.time_remaining = rem;
				if (stat[dem_lv].full) begin
					res.status = ST_DROPPED;
				end else begin
					res.status        = ST_DEMOTED;
					cmd[dem_lv].push  = go;
					cmd[dem_lv].wdata = '{id: head.id, burst: rem, prio: head.prio};
				end
			end else begin
				res.status = ST_FINISHED;
			end
		end
	end

endmodule
